/* sv/node_liveness_table_macros.svh */
// assertion macros used by the node liveness table controller
`ifndef NODE_LIVENESS_TABLE_MACROS_SVH
`define NODE_LIVENESS_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define NLT_ASSERT_IMP(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define NLT_ASSERT_NXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

/* sv/nlt_pkg.sv */
// types, codes and constants of the node liveness table
package nlt_pkg;

   localparam int SLOTS   = 32;
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_W = 6;

   localparam logic [COUNT_W-1:0] COUNT_SAT          = COUNT_W'(63);
   localparam logic [7:0]         ID_MAX_VALID       = 8'd127;
   localparam logic [31:0]        COUNT_TIMEOUT_RESET = 32'd5000;

   localparam logic [1:0] OP_HEARTBEAT = 2'd0;
   localparam logic [1:0] OP_QUERY     = 2'd1;
   localparam logic [1:0] OP_COUNT     = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_INVALID_ID = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;

   localparam int CSR_AW = 3;
   localparam logic REG_COUNT_TIMEOUT = 1'b0;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  node_id;
      logic [1:0]  health;
      logic [2:0]  mode;
      logic [31:0] uptime_s;
      logic [31:0] query_timeout_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               node_alive;
      logic [COUNT_W-1:0] alive_count;
      logic [COUNT_W-1:0] registered_count;
      logic [1:0]         found_health;
      logic [2:0]         found_mode;
      logic [31:0]        found_uptime_s;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  node_id;
      logic [1:0]  health;
      logic [2:0]  mode;
      logic [31:0] uptime;
      logic [31:0] last_seen;
   } slot_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_AW-1:0] addr;
      slot_type           data;
   } ram_wr_type;

   typedef struct packed {
      logic [31:0] now;
      logic [31:0] seen;
      logic [31:0] limit;
   } age_req_type;

endpackage

/* sv/nlt_slot_ram.sv */
// slot storage: one write port, one registered read port
module nlt_slot_ram
   import nlt_pkg::*;
(
   input  logic               clock,
   input  ram_wr_type         wr,
   input  logic [SLOT_AW-1:0] raddr,
   output slot_type           rdata
);

   slot_type mem [SLOTS];
   slot_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/nlt_age_unit.sv */
// shared age check: wrapped (now - seen) against a limit
module nlt_age_unit
   import nlt_pkg::*;
(
   input  age_req_type req,
   output logic        in_limit
);

   logic [31:0] age;

   assign age      = req.now - req.seen;
   assign in_limit = (age <= req.limit);

endmodule

/* sv/nlt_ctrl.sv */
// sequencer: slot scan, valid bits, claim count and result register
`include "node_liveness_table_macros.svh"

module nlt_ctrl
   import nlt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic [31:0]        count_timeout,
   output ram_wr_type         ram_wr,
   output logic [SLOT_AW-1:0] ram_raddr,
   input  slot_type           ram_rdata,
   output age_req_type        age_req,
   input  logic               age_within
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOTS - 1);

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic [SLOT_AW-1:0] iss_ff, iss_in;
   logic               eval_vld_ff, eval_vld_in;
   logic [SLOT_AW-1:0] eval_idx_ff, eval_idx_in;
   logic               eval_last_ff, eval_last_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [COUNT_W-1:0] claimed_ff, claimed_in;
   logic               hit_ff, hit_in;
   logic [SLOT_AW-1:0] hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [SLOT_AW-1:0] free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               alive_ff, alive_in;
   logic [1:0]         fhealth_ff, fhealth_in;
   logic [2:0]         fmode_ff, fmode_in;
   logic [31:0]        fuptime_ff, fuptime_in;

   logic       accept;
   logic       id_ok;
   logic       slot_v;
   ram_wr_type wr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = rsp_ff;
   assign ram_raddr = iss_ff;
   assign ram_wr    = wr;

   assign id_ok  = (req_data.node_id != 8'd0) && (req_data.node_id <= ID_MAX_VALID);
   assign slot_v = valid_ff[eval_idx_ff];

   // count uses the configured limit, query its own
   assign age_req.now   = req_ff.now_ms;
   assign age_req.seen  = ram_rdata.last_seen;
   assign age_req.limit = (req_ff.opcode == OP_COUNT) ? count_timeout : req_ff.query_timeout_ms;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      iss_in       = iss_ff;
      eval_vld_in  = (state_ff == ST_SCAN);
      eval_idx_in  = iss_ff;
      eval_last_in = (iss_ff == LAST_SLOT);
      valid_in     = valid_ff;
      claimed_in   = claimed_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      cnt_in       = cnt_ff;
      alive_in     = alive_ff;
      fhealth_in   = fhealth_ff;
      fmode_in     = fmode_ff;
      fuptime_in   = fuptime_ff;
      wr.en        = 1'b0;
      wr.addr      = hit_idx_ff;
      wr.data.node_id   = req_ff.node_id;
      wr.data.health    = req_ff.health;
      wr.data.mode      = req_ff.mode;
      wr.data.uptime    = req_ff.uptime_s;
      wr.data.last_seen = req_ff.now_ms;

      // one slot evaluated per cycle, in the cycle after its read address is issued
      if (eval_vld_ff) begin
         if (slot_v && (ram_rdata.node_id == req_ff.node_id)) begin
            hit_in     = 1'b1;
            hit_idx_in = eval_idx_ff;
            alive_in   = age_within;
            fhealth_in = ram_rdata.health;
            fmode_in   = ram_rdata.mode;
            fuptime_in = ram_rdata.uptime;
         end
         if (!slot_v && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = eval_idx_ff;
         end
         if (slot_v && age_within && (cnt_ff != COUNT_SAT)) begin
            cnt_in = cnt_ff + COUNT_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               iss_in     = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               cnt_in     = '0;
               alive_in   = 1'b0;
               fhealth_in = '0;
               fmode_in   = '0;
               fuptime_in = '0;
               rsp_in     = '0;
               if (req_data.opcode == OP_CLEAR) begin
                  valid_in   = '0;
                  claimed_in = '0;
                  state_in   = ST_DONE;
               end else if ((req_data.opcode != OP_COUNT) && !id_ok) begin
                  rsp_in.status           = STATUS_INVALID_ID;
                  rsp_in.registered_count = claimed_ff;
                  state_in                = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            iss_in = iss_ff + SLOT_AW'(1);
            if (iss_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_in = '0;
            case (req_ff.opcode)
               OP_HEARTBEAT: begin
                  if (hit_ff) begin
                     wr.en = 1'b1;
                  end else if (free_ff) begin
                     wr.en                 = 1'b1;
                     wr.addr               = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     if (claimed_ff != COUNT_SAT) begin
                        claimed_in = claimed_ff + COUNT_W'(1);
                     end
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end
               OP_QUERY: begin
                  rsp_in.node_alive     = alive_ff;
                  rsp_in.found_health   = fhealth_ff;
                  rsp_in.found_mode     = fmode_ff;
                  rsp_in.found_uptime_s = fuptime_ff;
               end
               OP_COUNT: begin
                  rsp_in.alive_count = cnt_ff;
               end
               default: begin
                  rsp_in.status = STATUS_OK;
               end
            endcase
            rsp_in.registered_count = claimed_in;
            state_in                = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         eval_vld_ff <= 1'b0;
         valid_ff    <= '0;
         claimed_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         eval_vld_ff <= eval_vld_in;
         valid_ff    <= valid_in;
         claimed_ff  <= claimed_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      iss_ff       <= iss_in;
      eval_idx_ff  <= eval_idx_in;
      eval_last_ff <= eval_last_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      cnt_ff       <= cnt_in;
      alive_ff     <= alive_in;
      fhealth_ff   <= fhealth_in;
      fmode_ff     <= fmode_in;
      fuptime_ff   <= fuptime_in;
   end

   `NLT_ASSERT_IMP(a_busy_while_result, rsp_valid, req_stall, "input taken while result pending")
   `NLT_ASSERT_IMP(a_drain_on_last, state_ff == ST_DRAIN, eval_vld_ff && eval_last_ff, "drain without last slot")
   `NLT_ASSERT_NXT(a_accept_busy, accept, state_ff != ST_IDLE, "idle right after transfer")
   `NLT_ASSERT_IMP(a_write_in_finish, wr.en, (state_ff == ST_FINISH) && (req_ff.opcode == OP_HEARTBEAT), "slot write outside heartbeat finish")

endmodule

/* sv/node_liveness_table.sv */
// top level of the node liveness table: csr register and unit wiring
//
//   channel   direction   handshake                     payload
//   req       in          req_valid / req_stall          req_type
//   rsp       out         rsp_valid / rsp_stall          rsp_type
//   csr       in          csr_psel/penable/pwrite/pready count_timeout_ms
//
// heartbeat, query and count pass through the scan, drain and finish states before the result:
// one slot is read and checked per cycle through the slot ram and the shared age unit
// clear and invalid-id items go straight from idle to the done state with their result
// the next input transfer is taken in the cycle after the result transfer
// synchronous reset empties the table and restores count_timeout_ms to 5000
module node_liveness_table
   import nlt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [31:0]        count_timeout_ff, count_timeout_in;
   logic               csr_hit;
   ram_wr_type         ram_wr;
   logic [SLOT_AW-1:0] ram_raddr;
   slot_type           ram_rdata;
   age_req_type        age_req;
   logic               age_within;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1:2] == REG_COUNT_TIMEOUT);
   assign csr_prdata = csr_hit ? count_timeout_ff : 32'd0;

   always_comb begin
      count_timeout_in = count_timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         count_timeout_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_timeout_ff <= COUNT_TIMEOUT_RESET;
      end else begin
         count_timeout_ff <= count_timeout_in;
      end
   end

   nlt_slot_ram u_ram (
      .clock (clock),
      .wr    (ram_wr),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   nlt_age_unit u_age (
      .req      (age_req),
      .in_limit (age_within)
   );

   nlt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .count_timeout (count_timeout_ff),
      .ram_wr        (ram_wr),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .age_req       (age_req),
      .age_within    (age_within)
   );

endmodule
